[sv/wdo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdo_pkg
// Shared types, constants and the arctangent table for the odometry block.
// ----------------------------------------------------------------------------
package wdo_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_METERS_PER_TICK = 2'd0;
  localparam logic [1:0] REG_TURN_PER_TICK   = 2'd1;

  // Encoder wraparound correction.
  localparam int WRAP_SPAN  = 1048576;
  localparam int WRAP_LIMIT = 524288;

  // CORDIC length, capped at the table size.
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_RUN   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam logic [33:0] CORDIC_GAIN = 34'sd652032874;

  // Operand and product widths of the shared multiplier.
  localparam int MUL_AW = 25;
  localparam int MUL_BW = 33;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  typedef logic signed [MUL_AW-1:0] mul_a_t;
  typedef logic signed [MUL_BW-1:0] mul_b_t;
  typedef logic signed [MUL_PW-1:0] mul_p_t;
  typedef logic signed [33:0]       cordic_t;

  // atan(2^-i) as a binary angle (2^32 per turn).
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    begin
      case (idx)
        5'd0:  v = 30'd536870912;
        5'd1:  v = 30'd316933406;
        5'd2:  v = 30'd167458907;
        5'd3:  v = 30'd85004756;
        5'd4:  v = 30'd42667331;
        5'd5:  v = 30'd21354465;
        5'd6:  v = 30'd10679838;
        5'd7:  v = 30'd5340245;
        5'd8:  v = 30'd2670163;
        5'd9:  v = 30'd1335087;
        5'd10: v = 30'd667544;
        5'd11: v = 30'd333772;
        5'd12: v = 30'd166886;
        5'd13: v = 30'd83443;
        5'd14: v = 30'd41722;
        5'd15: v = 30'd20861;
        5'd16: v = 30'd10430;
        5'd17: v = 30'd5215;
        5'd18: v = 30'd2608;
        5'd19: v = 30'd1304;
        5'd20: v = 30'd652;
        5'd21: v = 30'd326;
        5'd22: v = 30'd163;
        5'd23: v = 30'd81;
        5'd24: v = 30'd41;
        5'd25: v = 30'd20;
        5'd26: v = 30'd10;
        5'd27: v = 30'd5;
        5'd28: v = 30'd3;
        5'd29: v = 30'd1;
        5'd30: v = 30'd1;
        default: v = 30'd0;
      endcase
      return v;
    end
  endfunction

endpackage

[sv/wrapping_diff_drive_odometry.sv]
`timescale 1ns / 1ps
// Timing: the first beat after reset is answered in the cycle after it is
// taken. A later beat steps through S_MC, S_MT and S_CS, waits in S_CW for
// the CORDIC (24 steps), then runs S_M0, S_M1 and S_ACC once for x and once
// for y, making six passes through the shared multiplier in all.
// Throughput: one beat at a time; none is taken while busy or while the last pose is stalled.
// Synchronous active-low reset clears the pose, last counts, configuration and control state.
// ----------------------------------------------------------------------------
// wrapping_diff_drive_odometry
// Differential-drive odometry with encoder wrap correction.
// ----------------------------------------------------------------------------
module wrapping_diff_drive_odometry
  import wdo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [20:0] in_left_count,
  input  logic signed [20:0] in_right_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_pos_x,
  output logic signed [47:0] out_pos_y,
  output logic signed [31:0] out_heading
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MC   = 4'd1;
  localparam logic [3:0] S_MT   = 4'd2;
  localparam logic [3:0] S_CS   = 4'd3;
  localparam logic [3:0] S_CW   = 4'd4;
  localparam logic [3:0] S_M0   = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;

  localparam logic signed [22:0] LIM  = 23'(WRAP_LIMIT);
  localparam logic signed [22:0] SPAN = 23'(WRAP_SPAN);

  logic [3:0]         state_r, state_nxt;
  logic [31:0]        mpt_r, tpt_r;
  logic signed [20:0] last_l_r, last_r_r;
  logic               primed_r;
  logic [47:0]        px_r, px_nxt, py_r, py_nxt;
  logic [31:0]        ang_r, ang_nxt;
  logic               ov_r, ov_nxt;
  logic signed [23:0] dsum_r, ddiff_r;
  logic signed [47:0] ctr_r;
  logic [31:0]        turn_r;
  cordic_t            cos_r, sin_r;
  logic               sel_r;
  logic [54:0]        p1_r;

  logic               accept;
  logic signed [22:0] rl, rr, dl, dr;
  mul_a_t             ma;
  mul_b_t             mb;
  mul_p_t             prod;
  logic               c_start, c_done;
  cordic_t            c_cos, c_sin, trig;
  logic [47:0]        ua;
  logic [31:0]        uc;
  logic               neg;
  logic [55:0]        qsum;
  logic [47:0]        q, dq;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || ov_r;

  // Wrap-corrected deltas.
  assign rl = 23'(in_left_count) - 23'(last_l_r);
  assign rr = 23'(in_right_count) - 23'(last_r_r);
  assign dl = (rl > LIM) ? rl - SPAN : ((rl < -LIM) ? rl + SPAN : rl);
  assign dr = (rr > LIM) ? rr - SPAN : ((rr < -LIM) ? rr + SPAN : rr);

  // Magnitudes and sign for the scaled step.
  assign trig = sel_r ? sin_r : cos_r;
  assign ua   = ctr_r[47] ? -ctr_r : ctr_r;
  assign uc   = trig[33] ? 32'(-trig) : 32'(trig);
  assign neg  = ctr_r[47] ^ trig[33];
  assign qsum = 56'(p1_r) + 56'(prod[54:23]);
  assign q    = qsum[54:7];
  assign dq   = neg ? -q : q;

  // Multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_MC: begin
        ma = mul_a_t'(dsum_r);
        mb = mul_b_t'({1'b0, mpt_r});
      end
      S_MT: begin
        ma = mul_a_t'(ddiff_r);
        mb = mul_b_t'({1'b0, tpt_r});
      end
      S_M0: begin
        ma = mul_a_t'({2'b00, ua[45:23]});
        mb = mul_b_t'({1'b0, uc});
      end
      S_M1: begin
        ma = mul_a_t'({2'b00, ua[22:0]});
        mb = mul_b_t'({1'b0, uc});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  wdo_mul u_mul (
    .clk    (clk),
    .op_a   (ma),
    .op_b   (mb),
    .prod_r (prod)
  );

  assign c_start = (state_r == S_CS);

  wdo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (c_start),
    .angle   (ang_r + prod[32:1]),
    .done    (c_done),
    .cos_out (c_cos),
    .sin_out (c_sin)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    ang_nxt   = ang_r;
    ov_nxt    = ov_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (primed_r) begin
            state_nxt = S_MC;
          end else begin
            ov_nxt = 1'b1;
          end
        end
      end
      S_MC:  state_nxt = S_MT;
      S_MT:  state_nxt = S_CS;
      S_CS:  state_nxt = S_CW;
      S_CW: begin
        if (c_done) begin
          state_nxt = S_M0;
        end
      end
      S_M0:  state_nxt = S_M1;
      S_M1:  state_nxt = S_ACC;
      S_ACC: begin
        if (!sel_r) begin
          px_nxt    = px_r + dq;
          state_nxt = S_M0;
        end else begin
          py_nxt    = py_r + dq;
          ang_nxt   = ang_r + turn_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mpt_r    <= '0;
      tpt_r    <= '0;
      last_l_r <= '0;
      last_r_r <= '0;
      primed_r <= 1'b0;
      px_r     <= '0;
      py_r     <= '0;
      ang_r    <= '0;
      ov_r     <= 1'b0;
      sel_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      ang_r   <= ang_nxt;
      ov_r    <= ov_nxt;
      // Configuration writes; unknown indexes are dropped.
      if (cfg_we) begin
        case (cfg_addr)
          REG_METERS_PER_TICK: mpt_r <= cfg_wdata;
          REG_TURN_PER_TICK:   tpt_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (accept) begin
        last_l_r <= in_left_count;
        last_r_r <= in_right_count;
        primed_r <= 1'b1;
      end
      if (state_r == S_MC) begin
        sel_r <= 1'b0;
      end else if (state_r == S_ACC) begin
        sel_r <= 1'b1;
      end
    end
  end

  // Datapath holding registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      dsum_r  <= 24'(dl) + 24'(dr);
      ddiff_r <= 24'(dr) - 24'(dl);
    end
    if (state_r == S_MT) begin
      ctr_r <= prod[56:9];
    end
    if (state_r == S_CS) begin
      turn_r <= prod[31:0];
    end
    if (state_r == S_CW && c_done) begin
      cos_r <= c_cos;
      sin_r <= c_sin;
    end
    if (state_r == S_M1) begin
      p1_r <= prod[54:0];
    end
  end

  assign out_valid   = ov_r;
  assign out_pos_x   = px_r;
  assign out_pos_y   = py_r;
  assign out_heading = ang_r;

endmodule

[sv/wdo_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wdo_mul
  import wdo_pkg::*;
(
  input  logic   clk,
  input  mul_a_t op_a,
  input  mul_b_t op_b,
  output mul_p_t prod_r
);

  mul_p_t prod_nxt;

  // One product per cycle, available the cycle after the operands.
  assign prod_nxt = mul_p_t'(op_a) * mul_p_t'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

[sv/wdo_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdo_cordic
// Iterative rotation-mode CORDIC: one add/shift step per cycle.
// ----------------------------------------------------------------------------
module wdo_cordic
  import wdo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] angle,
  output logic        done,
  output cordic_t     cos_out,
  output cordic_t     sin_out
);

  logic        busy_r, busy_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        fold_r, fold_nxt;
  cordic_t     x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  cordic_t     x_sh, y_sh, atan_v;
  logic        fold_in;
  logic        last;

  assign fold_in = angle[31] ^ angle[30];
  assign x_sh    = x_r >>> step_r;
  assign y_sh    = y_r >>> step_r;
  assign atan_v  = cordic_t'(atan_lut(step_r));
  assign last    = (step_r == 5'(CORDIC_RUN - 1));

  // Load on start, then rotate toward zero residual angle.
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    fold_nxt = fold_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 5'd0;
      fold_nxt = fold_in;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = cordic_t'($signed({angle[31] ^ fold_in, angle[30:0]}));
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - y_sh;
        y_nxt = y_r + x_sh;
        z_nxt = z_r - atan_v;
      end else begin
        x_nxt = x_r + y_sh;
        y_nxt = y_r - x_sh;
        z_nxt = z_r + atan_v;
      end
      step_nxt = step_r + 5'd1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done   <= busy_r && last && !start;
    end
    step_r <= step_nxt;
    fold_r <= fold_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  // Undo the half-turn fold.
  assign cos_out = fold_r ? -x_r : x_r;
  assign sin_out = fold_r ? -y_r : y_r;

endmodule
